// File: rtl/tlb_with_page_walk_core_defines.svh
// assertion macros for the translation buffer
`ifndef TLB_WITH_PAGE_WALK_CORE_DEFINES_SVH
`define TLB_WITH_PAGE_WALK_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define TLBW_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TLBW_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define TLBW_ASSERT(label, clk, rst_n, prop, msg)
`define TLBW_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif

`endif

// File: rtl/tlbw_pkg.sv
package tlbw_pkg;

    localparam int ENTRIES   = 64;
    localparam int IDX_W     = $clog2(ENTRIES);
    localparam int CNT_W     = $clog2(ENTRIES + 1);
    localparam int TAG_W     = 20;
    localparam int PTE_W     = 32;
    localparam int ADDR_W    = 32;
    localparam int PG_SHIFT  = 12;
    localparam int DIR_SHIFT = 22;
    localparam int IDX_BITS  = 10;
    localparam int LFSR_W    = 16;
    localparam int ENT_W     = TAG_W + PTE_W;

    localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;
    localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;

    localparam logic [1:0] CMD_LOOKUP = 2'd0;
    localparam logic [1:0] CMD_RESP   = 2'd1;
    localparam logic [1:0] CMD_FLUSH  = 2'd2;

    typedef enum logic [2:0] {
        K_XLATE = 3'd0,
        K_READ  = 3'd1,
        K_FAULT = 3'd2,
        K_FLUSH = 3'd3,
        K_BUSY  = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_DIR  = 2'd1,
        PH_TAB  = 2'd2
    } t_phase;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_SCAN = 1'b1
    } t_state;

endpackage

// File: rtl/tlb_with_page_walk_core.sv
// lookup: one request per entry scan; the scan ends on a tag hit or after the last entry
// response, fault and flush results are registered and appear in the cycle after the request is accepted
// the scan reads one tag/pte word per cycle from the entry memory with separate read and write ports
// i_rst_n is synchronous and active low: valid marks, walk phase and output valid are
// cleared, the lfsr is loaded with its seed; the entry memory itself is not initialized
`include "tlb_with_page_walk_core_defines.svh"

module tlb_with_page_walk_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [19:0] i_cfg_wdata,      // page_dir_base
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [63:0] i_s_axis_tdata,   // lin_addr[31:0], mem_data[63:32]
    input  logic [1:0]  i_s_axis_tuser,   // cmd
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [71:0] o_m_axis_tdata,   // pte_out[31:0], was_hit[32], read_addr[64:33], zero pad
    output logic [2:0]  o_m_axis_tuser    // kind
);

    localparam int IDX_W = tlbw_pkg::IDX_W;
    localparam int CNT_W = tlbw_pkg::CNT_W;

    logic [tlbw_pkg::TAG_W-1:0]   r_dir_base;
    logic [tlbw_pkg::ENTRIES-1:0] r_valid;
    tlbw_pkg::t_state             r_state, n_state;
    tlbw_pkg::t_phase             r_phase, n_phase;
    logic [31:0]                  r_pend;
    logic [tlbw_pkg::LFSR_W-1:0]  r_lfsr, n_lfsr;
    logic [CNT_W-1:0]             r_idx;
    logic                         r_rd_valid;
    logic [IDX_W-1:0]             r_rd_idx;

    logic              r_out_valid;
    tlbw_pkg::t_kind   r_out_kind;
    logic [31:0]       r_out_pte;
    logic              r_out_hit;
    logic [31:0]       r_out_addr;

    logic [1:0]  cmd;
    logic [31:0] lin;
    logic [31:0] mdata;
    logic        acc;
    logic        out_take;

    logic                      ram_we;
    logic [IDX_W-1:0]          ram_waddr;
    logic [tlbw_pkg::ENT_W-1:0] ram_wdata;
    logic                      ram_re;
    logic [IDX_W-1:0]          ram_raddr;
    logic [tlbw_pkg::ENT_W-1:0] ram_rdata;

    logic        scan_hit;
    logic        scan_last;
    logic        res_valid;
    tlbw_pkg::t_kind res_kind;
    logic [31:0] res_pte;
    logic        res_hit;
    logic [31:0] res_addr;
    logic        start_scan;
    logic        clear_all;

    logic             free_found;
    logic [IDX_W-1:0] free_idx;
    logic [tlbw_pkg::LFSR_W-1:0] lfsr_step;

    assign cmd      = i_s_axis_tuser;
    assign lin      = i_s_axis_tdata[31:0];
    assign mdata    = i_s_axis_tdata[63:32];
    assign acc      = i_s_axis_tvalid && o_s_axis_tready;
    assign out_take = r_out_valid && i_m_axis_tready;

    assign scan_hit  = r_rd_valid && r_valid[r_rd_idx]
                       && (ram_rdata[tlbw_pkg::ENT_W-1:tlbw_pkg::PTE_W]
                           == r_pend[31:tlbw_pkg::PG_SHIFT]);
    assign scan_last = r_rd_valid && (r_rd_idx == IDX_W'(tlbw_pkg::ENTRIES - 1));

    tlbw_ram #(
        .WIDTH (tlbw_pkg::ENT_W),
        .DEPTH (tlbw_pkg::ENTRIES)
    ) u_entries (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // lowest free slot
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = tlbw_pkg::ENTRIES - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    assign lfsr_step = {1'b0, r_lfsr[tlbw_pkg::LFSR_W-1:1]}
                       ^ (r_lfsr[0] ? tlbw_pkg::LFSR_TAPS : '0);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tlbw_pkg::S_IDLE: begin
                if (start_scan) begin
                    n_state = tlbw_pkg::S_SCAN;
                end
            end
            tlbw_pkg::S_SCAN: begin
                if (scan_hit || scan_last) begin
                    n_state = tlbw_pkg::S_IDLE;
                end
            end
            default: n_state = tlbw_pkg::S_IDLE;
        endcase
    end

    // outputs of the state machine
    always_comb begin
        o_s_axis_tready = (r_state == tlbw_pkg::S_IDLE) && (!r_out_valid || i_m_axis_tready);
        ram_re          = (r_state == tlbw_pkg::S_SCAN)
                          && (r_idx < CNT_W'(tlbw_pkg::ENTRIES));
        ram_raddr       = r_idx[IDX_W-1:0];
    end

    // request handling and result formation
    always_comb begin
        res_valid  = 1'b0;
        res_kind   = tlbw_pkg::K_BUSY;
        res_pte    = '0;
        res_hit    = 1'b0;
        res_addr   = '0;
        n_phase    = r_phase;
        n_lfsr     = r_lfsr;
        ram_we     = 1'b0;
        ram_waddr  = free_idx;
        ram_wdata  = {r_pend[31:tlbw_pkg::PG_SHIFT], mdata};
        start_scan = 1'b0;
        clear_all  = 1'b0;
        if (r_state == tlbw_pkg::S_SCAN) begin
            if (scan_hit) begin
                res_valid = 1'b1;
                res_kind  = tlbw_pkg::K_XLATE;
                res_pte   = ram_rdata[tlbw_pkg::PTE_W-1:0];
                res_hit   = 1'b1;
            end else if (scan_last) begin
                res_valid = 1'b1;
                res_kind  = tlbw_pkg::K_READ;
                res_addr  = {r_dir_base, 12'b0}
                            + {20'b0, r_pend[31:tlbw_pkg::DIR_SHIFT], 2'b0};
                n_phase   = tlbw_pkg::PH_DIR;
            end
        end else if (acc) begin
            res_valid = 1'b1;
            priority if (cmd == tlbw_pkg::CMD_FLUSH) begin
                res_kind  = tlbw_pkg::K_FLUSH;
                n_phase   = tlbw_pkg::PH_IDLE;
                clear_all = 1'b1;
            end else if (cmd == tlbw_pkg::CMD_LOOKUP && r_phase == tlbw_pkg::PH_IDLE) begin
                res_valid  = 1'b0;
                start_scan = 1'b1;
            end else if (cmd == tlbw_pkg::CMD_RESP && r_phase == tlbw_pkg::PH_DIR) begin
                if (!mdata[0]) begin
                    res_kind = tlbw_pkg::K_FAULT;
                    n_phase  = tlbw_pkg::PH_IDLE;
                end else begin
                    res_kind = tlbw_pkg::K_READ;
                    res_addr = {mdata[31:tlbw_pkg::PG_SHIFT], 12'b0}
                               + {20'b0, r_pend[21:tlbw_pkg::PG_SHIFT], 2'b0};
                    n_phase  = tlbw_pkg::PH_TAB;
                end
            end else if (cmd == tlbw_pkg::CMD_RESP && r_phase == tlbw_pkg::PH_TAB) begin
                n_phase = tlbw_pkg::PH_IDLE;
                if (!mdata[0]) begin
                    res_kind = tlbw_pkg::K_FAULT;
                end else begin
                    res_kind = tlbw_pkg::K_XLATE;
                    res_pte  = mdata;
                    ram_we   = 1'b1;
                    if (!free_found) begin
                        n_lfsr    = lfsr_step;
                        ram_waddr = IDX_W'(lfsr_step % tlbw_pkg::ENTRIES);
                    end
                end
            end else begin
                res_kind = tlbw_pkg::K_BUSY;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir_base  <= '0;
            r_valid     <= '0;
            r_state     <= tlbw_pkg::S_IDLE;
            r_phase     <= tlbw_pkg::PH_IDLE;
            r_pend      <= '0;
            r_lfsr      <= tlbw_pkg::LFSR_SEED;
            r_idx       <= '0;
            r_rd_valid  <= 1'b0;
            r_rd_idx    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_dir_base <= i_cfg_wdata;
            end
            r_state <= n_state;
            r_phase <= n_phase;
            r_lfsr  <= n_lfsr;
            if (clear_all) begin
                r_valid <= '0;
            end else if (ram_we) begin
                r_valid[ram_waddr] <= 1'b1;
            end
            if (start_scan) begin
                r_pend <= lin;
                r_idx  <= '0;
            end else if (ram_re) begin
                r_idx <= r_idx + CNT_W'(1);
            end
            r_rd_valid <= ram_re && !scan_hit;
            r_rd_idx   <= ram_raddr;
            if (res_valid) begin
                r_out_valid <= 1'b1;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out_kind <= res_kind;
            r_out_pte  <= res_pte;
            r_out_hit  <= res_hit;
            r_out_addr <= res_addr;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_kind;
    assign o_m_axis_tdata  = {7'b0, r_out_addr, r_out_hit, r_out_pte};

    `TLBW_ASSERT(a_scan_out_empty, i_clk, i_rst_n, (r_state == tlbw_pkg::S_SCAN) |-> !r_out_valid, "result pending during scan")
    `TLBW_ASSERT(a_install_phase, i_clk, i_rst_n, ram_we |-> (r_phase == tlbw_pkg::PH_TAB), "install outside table phase")
    `TLBW_ASSERT_NEVER(a_lfsr_zero, i_clk, i_rst_n, r_lfsr == '0, "victim lfsr locked at zero")
    `TLBW_ASSERT(a_walk_no_scan, i_clk, i_rst_n, (r_state == tlbw_pkg::S_SCAN) |-> (r_phase == tlbw_pkg::PH_IDLE), "scan during walk")

endmodule

// File: rtl/tlbw_ram.sv
module tlbw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: tb/tlb_xlate_checker.sv
module tlb_xlate_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [19:0] i_cfg_wdata,
    input  logic        i_s_axis_tvalid,
    input  logic        i_s_axis_tready,
    input  logic [63:0] i_s_axis_tdata,
    input  logic [1:0]  i_s_axis_tuser,
    input  logic        i_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    input  logic [71:0] i_m_axis_tdata,
    input  logic [2:0]  i_m_axis_tuser,
    output int          o_errors,
    output int          o_pending
);

    typedef struct packed {
        tlbw_pkg::t_kind kind;
        logic [31:0]     pte;
        logic            hit;
        logic [31:0]     raddr;
    } t_xlate;

    t_xlate                     expected_q[$];
    logic [19:0]                dir_base;
    logic                       slot_valid [tlbw_pkg::ENTRIES];
    logic [tlbw_pkg::TAG_W-1:0] slot_tag   [tlbw_pkg::ENTRIES];
    logic [31:0]                slot_pte   [tlbw_pkg::ENTRIES];
    tlbw_pkg::t_phase           phase;
    logic [31:0]                walk_addr;
    logic [15:0]                victim;

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        o_errors++;
    endtask

    function automatic t_xlate translate(input logic [1:0] cmd, input logic [31:0] lin,
                                         input logic [31:0] data);
        t_xlate r;
        int     slot;
        r = '{kind: tlbw_pkg::K_BUSY, pte: '0, hit: 1'b0, raddr: '0};
        if (cmd == tlbw_pkg::CMD_FLUSH) begin
            foreach (slot_valid[i]) slot_valid[i] = 1'b0;
            phase  = tlbw_pkg::PH_IDLE;
            r.kind = tlbw_pkg::K_FLUSH;
        end else if (cmd == tlbw_pkg::CMD_LOOKUP) begin
            if (phase == tlbw_pkg::PH_IDLE) begin
                slot = -1;
                for (int i = 0; i < tlbw_pkg::ENTRIES; i++)
                    if (slot < 0 && slot_valid[i] && slot_tag[i] == lin[31:12]) slot = i;
                if (slot >= 0) begin
                    r.kind = tlbw_pkg::K_XLATE;
                    r.pte  = slot_pte[slot];
                    r.hit  = 1'b1;
                end else begin
                    walk_addr = lin;
                    phase     = tlbw_pkg::PH_DIR;
                    r.kind    = tlbw_pkg::K_READ;
                    r.raddr   = {dir_base, 12'd0} + {20'd0, lin[31:22], 2'b00};
                end
            end
        end else if (cmd == tlbw_pkg::CMD_RESP && phase == tlbw_pkg::PH_DIR) begin
            if (!data[0]) begin
                phase  = tlbw_pkg::PH_IDLE;
                r.kind = tlbw_pkg::K_FAULT;
            end else begin
                phase   = tlbw_pkg::PH_TAB;
                r.kind  = tlbw_pkg::K_READ;
                r.raddr = {data[31:12], 12'd0} + {20'd0, walk_addr[21:12], 2'b00};
            end
        end else if (cmd == tlbw_pkg::CMD_RESP && phase == tlbw_pkg::PH_TAB) begin
            phase = tlbw_pkg::PH_IDLE;
            if (!data[0]) begin
                r.kind = tlbw_pkg::K_FAULT;
            end else begin
                slot = -1;
                for (int i = 0; i < tlbw_pkg::ENTRIES; i++)
                    if (slot < 0 && !slot_valid[i]) slot = i;
                if (slot < 0) begin
                    victim = victim[0] ? ((victim >> 1) ^ tlbw_pkg::LFSR_TAPS) : (victim >> 1);
                    slot   = victim % tlbw_pkg::ENTRIES;
                end
                slot_valid[slot] = 1'b1;
                slot_tag[slot]   = walk_addr[31:12];
                slot_pte[slot]   = data;
                r.kind = tlbw_pkg::K_XLATE;
                r.pte  = data;
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_xlate want;
        if (!i_rst_n) begin
            o_errors  = 0;
            dir_base  = '0;
            foreach (slot_valid[i]) slot_valid[i] = 1'b0;
            phase     = tlbw_pkg::PH_IDLE;
            walk_addr = '0;
            victim    = tlbw_pkg::LFSR_SEED;
            expected_q.delete();
        end else begin
            if (i_cfg_we) dir_base = i_cfg_wdata;
            if (i_s_axis_tvalid && i_s_axis_tready)
                expected_q.push_back(translate(i_s_axis_tuser, i_s_axis_tdata[31:0],
                                               i_s_axis_tdata[63:32]));
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (expected_q.size() == 0) begin
                    report("unexpected result", {29'd0, i_m_axis_tuser}, '0);
                end else begin
                    want = expected_q.pop_front();
                    if (i_m_axis_tuser != want.kind)
                        report("kind", {29'd0, i_m_axis_tuser}, {29'd0, want.kind});
                    if (i_m_axis_tdata[31:0] != want.pte)
                        report("pte_out", i_m_axis_tdata[31:0], want.pte);
                    if (i_m_axis_tdata[32] != want.hit)
                        report("was_hit", {31'd0, i_m_axis_tdata[32]}, {31'd0, want.hit});
                    if (i_m_axis_tdata[64:33] != want.raddr)
                        report("read_addr", i_m_axis_tdata[64:33], want.raddr);
                end
            end
        end
        o_pending = expected_q.size();
    end

endmodule

// File: tb/tb_tlb_with_page_walk_core.sv
module tb_tlb_with_page_walk_core;

    localparam int STALL_LIMIT = 20000;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [19:0] i_cfg_wdata = '0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [63:0] i_s_axis_tdata = '0;   // lin_addr[31:0], mem_data[63:32]
    logic [1:0]  i_s_axis_tuser = '0;   // cmd
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [71:0] o_m_axis_tdata;        // pte_out[31:0], was_hit[32], read_addr[64:33], zero pad
    logic [2:0]  o_m_axis_tuser;        // kind
    int          errors;
    int          pending;
    int          idle_cycles = 0;
    bit          hold_off = 1'b0;
    logic [31:0] page_pool [8];

    always #5 i_clk = ~i_clk;

    tlb_with_page_walk_core u_dut (.*);

    tlb_xlate_checker u_checker (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_wdata,
        .i_s_axis_tvalid, .i_s_axis_tready(o_s_axis_tready), .i_s_axis_tdata,
        .i_s_axis_tuser, .i_m_axis_tvalid(o_m_axis_tvalid), .i_m_axis_tready,
        .i_m_axis_tdata(o_m_axis_tdata), .i_m_axis_tuser(o_m_axis_tuser),
        .o_errors(errors), .o_pending(pending)
    );

    // request on the slave side, random gap before it
    task automatic send(input logic [1:0] cmd, input logic [31:0] lin, input logic [31:0] data);
        int gap;
        gap = $urandom_range(0, 4);
        if (gap != 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= cmd;
        i_s_axis_tdata  <= {data, lin};
        do @(posedge i_clk); while (!o_s_axis_tready);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (80) @(negedge i_clk);
    endtask

    task automatic set_base(input logic [19:0] base);
        i_s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= base;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // one walk: lookup, directory response, table response if the directory entry is valid
    task automatic walk(input logic [31:0] lin, input bit dir_ok, input bit tab_ok);
        send(tlbw_pkg::CMD_LOOKUP, lin, $urandom());
        send(tlbw_pkg::CMD_RESP, $urandom(), ($urandom() & 32'hffff_fffe) | {31'd0, dir_ok});
        if (dir_ok)
            send(tlbw_pkg::CMD_RESP, $urandom(),
                 ($urandom() & 32'hffff_fffe) | {31'd0, tab_ok});
    endtask

    always begin
        int wait_n;
        @(negedge i_clk);
        wait_n = $urandom_range(0, 4);
        if (hold_off) begin
            i_m_axis_tready <= 1'b0;
        end else if (wait_n == 0) begin
            i_m_axis_tready <= 1'b1;
        end else begin
            i_m_axis_tready <= 1'b0;
            repeat (wait_n) @(negedge i_clk);
            i_m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("tb_tlb_with_page_walk_core: FAIL");
            $finish;
        end
    end

    initial begin
        int sel;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        foreach (page_pool[i]) page_pool[i] = $urandom();

        // directed
        set_base(20'h00000);
        send(tlbw_pkg::CMD_RESP, '0, 32'hffffffff);
        send(CMD_UNUSED, '1, '1);
        walk(32'h0000_0000, 1, 1);
        send(tlbw_pkg::CMD_LOOKUP, 32'h0000_0fff, '0);
        walk(32'hffff_ffff, 1, 1);
        send(tlbw_pkg::CMD_LOOKUP, 32'hffff_f000, '0);
        walk(32'h1234_5678, 0, 0);
        walk(32'h1234_5678, 1, 0);
        send(tlbw_pkg::CMD_LOOKUP, 32'h8000_0000, '0);
        send(tlbw_pkg::CMD_LOOKUP, 32'h0000_0000, '0);
        send(tlbw_pkg::CMD_RESP, '0, 32'hffff_f001);
        send(tlbw_pkg::CMD_FLUSH, '0, '0);
        send(tlbw_pkg::CMD_LOOKUP, 32'h0000_0000, '0);
        send(tlbw_pkg::CMD_RESP, '0, 32'h0000_0001);
        send(tlbw_pkg::CMD_FLUSH, '0, '0);
        drain();
        set_base(20'hfffff);
        walk(32'hffc0_0000, 1, 1);
        drain();

        // fill past capacity so the lfsr picks victims
        set_base(20'($urandom()));
        for (int i = 0; i < 70; i++) walk({20'($urandom()), 12'h0}, 1, 1);
        drain();

        // long hold on the result side while requests keep coming
        hold_off = 1'b1;
        fork
            begin
                repeat (300) @(negedge i_clk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 10; i++) send(tlbw_pkg::CMD_LOOKUP, $urandom(), '0);
        join
        send(tlbw_pkg::CMD_FLUSH, '0, '0);
        drain();

        for (int p = 0; p < 4; p++) begin
            set_base(p == 0 ? 20'h0 : (p == 1 ? 20'hfffff : 20'($urandom())));
            for (int n = 0; n < 105; n++) begin
                sel = $urandom_range(0, 19);
                if (sel < 8)
                    send(tlbw_pkg::CMD_LOOKUP,
                         page_pool[$urandom_range(0, 7)] ^ $urandom_range(0, 4095),
                         $urandom());
                else if (sel < 15)
                    walk($urandom_range(0, 1) ? page_pool[$urandom_range(0, 7)] : $urandom(),
                         $urandom_range(0, 7) != 0, $urandom_range(0, 7) != 0);
                else if (sel < 17)
                    send(tlbw_pkg::CMD_RESP, $urandom(), $urandom());
                else if (sel < 18)
                    send(tlbw_pkg::CMD_FLUSH, $urandom(), $urandom());
                else
                    send(2'($urandom_range(0, 3)), $urandom(), $urandom());
            end
            drain();
        end

        if (errors == 0)
            $display("tb_tlb_with_page_walk_core: PASS");
        else
            $display("tb_tlb_with_page_walk_core: FAIL");
        $finish;
    end

endmodule

// File: tlb_with_page_walk_core.f
+incdir+rtl
rtl/tlbw_pkg.sv
rtl/tlbw_ram.sv
rtl/tlb_with_page_walk_core.sv
tb/tlb_xlate_checker.sv
tb/tb_tlb_with_page_walk_core.sv
